### rtl/core/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the address slot table: action and status
// codes, configuration register indexes, and the bundles between units.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int HANDLE_W   = 64;
    localparam int NODE_W     = 20;
    localparam int PROC_W     = 9;
    localparam int SLOT_W     = 10;
    localparam int ACTION_W   = 2;
    localparam int CTX_W      = 6;
    localparam int STEP_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int GROW_STEP_RESET = 256;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEP    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot_index;
        logic [NODE_W-1:0]   found_node;
        logic [PROC_W-1:0]   found_process;
    } t_result;

    // write controls from the sequencer to the slot store
    typedef struct packed {
        logic mark_we;
        logic mark_val;
        logic data_we;
    } t_wr_ctl;

    // read request from the sequencer to the slot store
    typedef struct packed {
        logic rd_en;
    } t_rd_ctl;

endpackage

### rtl/core/ast_store.sv
// ----------------------------------------------------------------------------
// ast_store
// Slot storage: valid marks and (node, process) entries, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module ast_store #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10
) (
    input  logic                        i_clk,
    input  ast_pkg::t_rd_ctl            i_rd,
    input  logic [IW-1:0]               i_rd_addr,
    input  ast_pkg::t_wr_ctl            i_wr,
    input  logic [IW-1:0]               i_wr_addr,
    input  logic [ast_pkg::NODE_W-1:0]  i_wr_node,
    input  logic [ast_pkg::PROC_W-1:0]  i_wr_proc,
    output logic                        o_rd_mark,
    output logic [ast_pkg::NODE_W-1:0]  o_rd_node,
    output logic [ast_pkg::PROC_W-1:0]  o_rd_proc
);
    import ast_pkg::*;

    logic                       mark_mem [TABLE_DEPTH];
    logic [NODE_W+PROC_W-1:0]   data_mem [TABLE_DEPTH];

    logic                       r_rd_mark;
    logic [NODE_W+PROC_W-1:0]   r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.mark_we) begin
            mark_mem[i_wr_addr] <= i_wr.mark_val;
        end
        if (i_wr.data_we) begin
            data_mem[i_wr_addr] <= {i_wr_node, i_wr_proc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.rd_en) begin
            r_rd_mark <= mark_mem[i_rd_addr];
            r_rd_data <= data_mem[i_rd_addr];
        end
    end

    assign o_rd_mark = r_rd_mark;
    assign o_rd_node = r_rd_data[NODE_W+PROC_W-1:PROC_W];
    assign o_rd_proc = r_rd_data[PROC_W-1:0];

endmodule

### rtl/core/ast_seq.sv
// ----------------------------------------------------------------------------
// ast_seq
// Request sequencer: clears the marks after reset, runs the next-fit scan
// with its cursor/size compare and growth adder, and builds each result.
// ----------------------------------------------------------------------------
module ast_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_req,
    input  logic [ast_pkg::ACTION_W-1:0]  i_action,
    input  logic [ast_pkg::HANDLE_W-1:0]  i_handle,
    input  logic [ast_pkg::NODE_W-1:0]    i_node_id,
    input  logic [ast_pkg::PROC_W-1:0]    i_process_id,
    output logic                          o_idle,
    // configuration
    input  logic                          i_read_only,
    input  logic [ast_pkg::CTX_W-1:0]     i_context_bits,
    input  logic [ast_pkg::STEP_W-1:0]    i_grow_step,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output ast_pkg::t_result              o_res,
    // slot store
    output ast_pkg::t_rd_ctl              o_rd,
    output logic [IW-1:0]                 o_rd_addr,
    output ast_pkg::t_wr_ctl              o_wr,
    output logic [IW-1:0]                 o_wr_addr,
    output logic [ast_pkg::NODE_W-1:0]    o_wr_node,
    output logic [ast_pkg::PROC_W-1:0]    o_wr_proc,
    input  logic                          i_rd_mark,
    input  logic [ast_pkg::NODE_W-1:0]    i_rd_node,
    input  logic [ast_pkg::PROC_W-1:0]    i_rd_proc
);
    import ast_pkg::*;

    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int GW = ((SW > STEP_W) ? SW : STEP_W) + 1;
    localparam int ResetSize =
        (GROW_STEP_RESET < TABLE_DEPTH) ? GROW_STEP_RESET : TABLE_DEPTH;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_TEST  = 6'b001000,
        S_LOOK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [SW-1:0]          r_cursor, n_cursor;
    logic [SW-1:0]          r_active, n_active;
    t_result                r_res, n_res;
    logic [NODE_W-1:0]      r_node, n_node;
    logic [PROC_W-1:0]      r_proc, n_proc;

    logic [HANDLE_W-1:0]    in_idx;
    logic                   in_range;
    logic [SLOT_W-1:0]      in_slot;
    logic [SW+SLOT_W-1:0]   cursor_ext;
    logic [GW-1:0]          step_ext;
    logic [GW-1:0]          grown;
    logic                   cursor_lt;

    // mask off the context bits, then bound against the active size
    assign in_idx    = i_handle & ({HANDLE_W{1'b1}} >> i_context_bits);
    assign in_range  = in_idx < HANDLE_W'(r_active);
    assign in_slot   = in_idx[SLOT_W-1:0];
    assign cursor_ext = {{SLOT_W{1'b0}}, r_cursor};

    // cursor/size compare and growth adder of the scan
    assign cursor_lt = r_cursor < r_active;
    assign step_ext  = (i_grow_step == '0) ? GW'(1) : GW'(i_grow_step);
    assign grown     = GW'(r_active) + step_ext;

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_active  = r_active;
        n_res     = r_res;
        n_node    = r_node;
        n_proc    = r_proc;
        o_rd      = '0;
        o_rd_addr = r_cursor[IW-1:0];
        o_wr      = '0;
        o_wr_addr = r_cursor[IW-1:0];
        o_wr_node = r_node;
        o_wr_proc = r_proc;

        case (r_state)
            S_CLEAR: begin
                o_wr.mark_we  = 1'b1;
                o_wr.mark_val = 1'b0;
                if (r_cursor == SW'(TABLE_DEPTH - 1)) begin
                    n_cursor = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cursor = r_cursor + SW'(1);
                end
            end
            S_IDLE: begin
                if (i_req) begin
                    n_node = i_node_id;
                    n_proc = i_process_id;
                    n_res  = '{status: ST_INVALID, slot_index: '0,
                               found_node: '0, found_process: '0};
                    case (i_action)
                        ACT_INSERT: begin
                            n_state = i_read_only ? S_DONE : S_SCAN;
                        end
                        ACT_REMOVE: begin
                            o_wr.mark_we   = in_range;
                            o_wr.mark_val  = 1'b0;
                            o_wr_addr      = in_idx[IW-1:0];
                            n_cursor       = '0;
                            n_res.status   = ST_OK;
                            n_res.slot_index = in_slot;
                            n_state        = S_DONE;
                        end
                        ACT_LOOKUP: begin
                            n_res.slot_index = in_slot;
                            o_rd.rd_en     = in_range;
                            o_rd_addr      = in_idx[IW-1:0];
                            n_state        = in_range ? S_LOOK : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (cursor_lt) begin
                    o_rd.rd_en = 1'b1;
                    n_state    = S_TEST;
                end else if (r_active < SW'(TABLE_DEPTH)) begin
                    n_active = (grown > GW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH)
                                                          : grown[SW-1:0];
                end else begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end
            end
            S_TEST: begin
                n_cursor = r_cursor + SW'(1);
                if (!i_rd_mark) begin
                    // claim the free slot
                    o_wr.mark_we     = 1'b1;
                    o_wr.mark_val    = 1'b1;
                    o_wr.data_we     = 1'b1;
                    n_res.status     = ST_OK;
                    n_res.slot_index = cursor_ext[SLOT_W-1:0];
                    n_state          = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_LOOK: begin
                if (i_rd_mark) begin
                    n_res.status        = ST_OK;
                    n_res.found_node    = i_rd_node;
                    n_res.found_process = i_rd_proc;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cursor <= '0;
            r_active <= SW'(ResetSize);
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_node <= n_node;
        r_proc <= n_proc;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

### rtl/core/address_slot_table_top.sv
// ----------------------------------------------------------------------------
// address_slot_table_top
// Next-fit table of (node, process) addresses with insert, remove and lookup.
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid marks and holds o_in_stall high
// meanwhile; configuration writes are taken at any time the block is idle.
// One request is worked at a time: a remove, a rejected insert or an unknown
// action goes straight to its result, a lookup in range makes one registered
// read of the slot store, and an insert scans slot by slot and grows the
// active size when the scan reaches its end; the scan reads one valid mark at
// a time through the store's single read port. The result sits in an output
// register, so the next request can enter while the previous result is still
// stalled.
// ----------------------------------------------------------------------------
module address_slot_table_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [ast_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [ast_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ast_pkg::ACTION_W-1:0]      i_action,
    input  logic [ast_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [ast_pkg::NODE_W-1:0]        i_node_id,
    input  logic [ast_pkg::PROC_W-1:0]        i_process_id,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [ast_pkg::SLOT_W-1:0]        o_slot_index,
    output logic [ast_pkg::NODE_W-1:0]        o_found_node,
    output logic [ast_pkg::PROC_W-1:0]        o_found_process
);
    import ast_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic                   r_read_only;
    logic [CTX_W-1:0]       r_context_bits;
    logic [STEP_W-1:0]      r_grow_step;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   seq_idle;
    logic                   res_valid;
    logic                   res_take;
    t_result                res;
    t_rd_ctl                rd_ctl;
    t_wr_ctl                wr_ctl;
    logic [IW-1:0]          rd_addr;
    logic [IW-1:0]          wr_addr;
    logic [NODE_W-1:0]      wr_node;
    logic [PROC_W-1:0]      wr_proc;
    logic                   rd_mark;
    logic [NODE_W-1:0]      rd_node;
    logic [PROC_W-1:0]      rd_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_only    <= 1'b0;
            r_context_bits <= '0;
            r_grow_step    <= STEP_W'(GROW_STEP_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_READ_ONLY:    r_read_only    <= i_cfg_wdata[0];
                CFG_CONTEXT_BITS: r_context_bits <= i_cfg_wdata[CTX_W-1:0];
                CFG_GROW_STEP:    r_grow_step    <= i_cfg_wdata[STEP_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    ast_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_in_valid && seq_idle),
        .i_action       (i_action),
        .i_handle       (i_handle),
        .i_node_id      (i_node_id),
        .i_process_id   (i_process_id),
        .o_idle         (seq_idle),
        .i_read_only    (r_read_only),
        .i_context_bits (r_context_bits),
        .i_grow_step    (r_grow_step),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res          (res),
        .o_rd           (rd_ctl),
        .o_rd_addr      (rd_addr),
        .o_wr           (wr_ctl),
        .o_wr_addr      (wr_addr),
        .o_wr_node      (wr_node),
        .o_wr_proc      (wr_proc),
        .i_rd_mark      (rd_mark),
        .i_rd_node      (rd_node),
        .i_rd_proc      (rd_proc)
    );

    ast_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd       (rd_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr       (wr_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_node  (wr_node),
        .i_wr_proc  (wr_proc),
        .o_rd_mark  (rd_mark),
        .o_rd_node  (rd_node),
        .o_rd_proc  (rd_proc)
    );

    assign o_in_stall      = !seq_idle;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_slot_index    = r_out.slot_index;
    assign o_found_node    = r_out.found_node;
    assign o_found_process = r_out.found_process;

endmodule

### rtl/core/ast_checker.sv
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks of the address slot table, bound to the top level.
// ----------------------------------------------------------------------------
module ast_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     o_status,
    input  logic [ast_pkg::SLOT_W-1:0]     o_slot_index,
    input  logic [ast_pkg::NODE_W-1:0]     o_found_node,
    input  logic [ast_pkg::PROC_W-1:0]     o_found_process
);
    import ast_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_slot_index) && $stable(o_found_node))
        else $error("stalled result changed");

    // one request at a time: after an accept the input side stalls
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK) || (o_status == ST_INVALID)
            || (o_status == ST_FULL))
        else $error("status out of range");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_slot_index == '0)
        else $error("full insert reported a slot");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK)
            |-> (o_found_node == '0) && (o_found_process == '0))
        else $error("address returned on failed request");

endmodule

bind address_slot_table_top ast_checker u_ast_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_slot_index    (o_slot_index),
    .o_found_node    (o_found_node),
    .o_found_process (o_found_process)
);
